/* hw/rtl/shwa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shwa_pkg: shared types and constants for the sample history window average
// Field widths, the accumulator width and the configuration register indexes.
// ----------------------------------------------------------------------------
package shwa_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int NET_W      = 25;
    localparam int CNT_W      = 5;
    // A sum of up to 31 signed 24-bit samples needs five extra bits.
    localparam int SUM_W      = SAMPLE_W + CNT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 1'b1;

    typedef logic        [SAMPLE_W-1:0]   raw_t;
    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic signed [NET_W-1:0]      net_t;
    typedef logic        [CNT_W-1:0]      count_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

endpackage

`default_nettype wire

/* hw/rtl/sample_history_window_average_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_history_window_average_top: windowed mean of load-cell samples
// Stores each sample in a circular history and returns the truncated mean of
// the newest samples together with the mean minus a tare offset.
// ----------------------------------------------------------------------------
// Each accepted sample is taken as a signed value and written one place past
// the newest history entry (the first sample after reset lands at index 1).
// The block then sums the newest average_count entries, walking backward with
// wrap, and divides the sum by the count with truncation toward zero. The sum
// walks the history memory through its single registered read port, one entry
// per cycle, and the division runs one quotient bit per cycle on the same adder
// that also forms the sum, the absolute value, the sign fix and the net value.
// sample_ready is high only while the sequencer is idle; a finished result
// sits in its own output register, so a new sample may be taken while the
// last result still waits. A count of zero is treated as one and a count
// above DEPTH as DEPTH. History entries never written since reset read as
// zero through a valid bit per entry, so no clearing pass is needed after
// reset. Configuration writes are taken in any cycle and are meant for when
// the block is idle.
// ----------------------------------------------------------------------------
module sample_history_window_average_top #(
    parameter int DEPTH = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    sample_valid,
    output logic                   sample_ready,
    input  wire  shwa_pkg::raw_t   raw_sample,
    output logic                   result_valid,
    input  wire                    result_ready,
    output shwa_pkg::sample_t      latest_sample,
    output shwa_pkg::sample_t      window_average,
    output shwa_pkg::net_t         net_value,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  shwa_pkg::cfg_idx_t  cfg_index,
    input  wire  shwa_pkg::cfg_data_t cfg_data
);
    import shwa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SIGN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;

    // Configuration registers.
    count_t                 avg_count_reg;
    sample_t                zero_offset_reg;

    // History memory with one valid bit per entry; an invalid entry reads as zero.
    sample_t                hist_mem [DEPTH];
    logic [DEPTH-1:0]       hist_vld_reg;
    logic [PTR_W-1:0]       wr_pos_reg;
    logic [PTR_W-1:0]       wr_pos_inc;
    logic                   mem_we;
    sample_t                mem_wdata;
    logic                   rd_en;
    logic [PTR_W-1:0]       rd_ptr_reg;
    sample_t                rd_data_reg;
    logic                   rd_vld_reg;
    logic                   rd_pend_reg;

    // Working registers.
    count_t                 cnt_reg;
    count_t                 div_reg;
    count_t                 rem_reg;
    count_t                 eff_count;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       dq_reg;
    logic                   neg_reg;
    sample_t                smp_reg;
    sample_t                avg_reg;

    // Output register.
    logic                   out_valid_reg;
    sample_t                latest_reg;
    sample_t                average_reg;
    net_t                   net_reg;

    // The one shared adder.
    logic [SUM_W-1:0]       add_a;
    logic [SUM_W-1:0]       add_b;
    logic                   add_cin;
    logic [SUM_W-1:0]       add_sum;

    logic                   in_fire;
    logic                   out_load;
    logic                   trial_ok;
    logic [CNT_W:0]         trial_in;

    assign sample_ready   = (state_reg == S_IDLE);
    assign cfg_ready      = 1'b1;
    assign in_fire        = sample_valid && sample_ready;
    assign result_valid   = out_valid_reg;
    assign latest_sample  = latest_reg;
    assign window_average = average_reg;
    assign net_value      = net_reg;

    assign wr_pos_inc = (wr_pos_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_pos_reg + 1'b1;
    assign mem_we     = in_fire;
    assign mem_wdata  = sample_t'(raw_sample);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || result_ready);

    // Effective count: zero means one, anything above the depth means the depth.
    always_comb
    begin
        eff_count = avg_count_reg;
        if (avg_count_reg == '0)
        begin
            eff_count = count_t'(1);
        end
        else if (32'(avg_count_reg) > DEPTH)
        begin
            eff_count = CNT_W'(DEPTH);
        end
    end

    // Division trial: the partial remainder shifted left by one dividend bit.
    assign trial_in = {rem_reg, dq_reg[SUM_W-1]};

    // Operand selection for the shared adder. Subtraction is add of the
    // complement with a carry in.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            S_SUM:
            begin
                add_a = acc_reg;
                add_b = rd_vld_reg ?
                        {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg} : '0;
            end
            S_ABS:
            begin
                add_b   = ~acc_reg;
                add_cin = 1'b1;
            end
            S_DIV:
            begin
                add_a   = {{(SUM_W-CNT_W-1){1'b0}}, trial_in};
                add_b   = ~{{(SUM_W-CNT_W){1'b0}}, div_reg};
                add_cin = 1'b1;
            end
            S_SIGN:
            begin
                add_b   = ~dq_reg;
                add_cin = 1'b1;
            end
            S_DONE:
            begin
                add_a   = {{(SUM_W-SAMPLE_W){avg_reg[SAMPLE_W-1]}}, avg_reg};
                add_b   = ~{{(SUM_W-SAMPLE_W){zero_offset_reg[SAMPLE_W-1]}},
                            zero_offset_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum  = add_a + add_b + {{(SUM_W-1){1'b0}}, add_cin};
    assign trial_ok = ~add_sum[SUM_W-1];
    assign rd_en    = (state_reg == S_SUM) && (cnt_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if ((cnt_reg == '0) && !rd_pend_reg)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wr_pos_inc] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_ptr_reg];
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            avg_count_reg   <= count_t'(1);
            zero_offset_reg <= '0;
            hist_vld_reg    <= '0;
            wr_pos_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            rd_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_vld_reg <= hist_vld_reg[rd_ptr_reg];
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_AVERAGE_COUNT: avg_count_reg   <= cfg_data[CNT_W-1:0];
                    REG_ZERO_OFFSET:   zero_offset_reg <= sample_t'(cfg_data);
                    default:           avg_count_reg   <= avg_count_reg;
                endcase
            end
            if (in_fire)
            begin
                wr_pos_reg               <= wr_pos_inc;
                hist_vld_reg[wr_pos_inc] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    smp_reg    <= mem_wdata;
                    acc_reg    <= '0;
                    cnt_reg    <= eff_count;
                    div_reg    <= eff_count;
                    rd_ptr_reg <= wr_pos_inc;
                end
            end
            S_SUM:
            begin
                if (rd_pend_reg)
                begin
                    acc_reg <= add_sum;
                end
                if (rd_en)
                begin
                    cnt_reg    <= cnt_reg - 1'b1;
                    rd_ptr_reg <= (rd_ptr_reg == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_reg - 1'b1;
                end
            end
            S_ABS:
            begin
                neg_reg <= acc_reg[SUM_W-1];
                dq_reg  <= acc_reg[SUM_W-1] ? add_sum : acc_reg;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(SUM_W - 1);
            end
            S_DIV:
            begin
                rem_reg <= trial_ok ? add_sum[CNT_W-1:0] : trial_in[CNT_W-1:0];
                dq_reg  <= {dq_reg[SUM_W-2:0], trial_ok};
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            S_SIGN:
            begin
                avg_reg <= neg_reg ? add_sum[SAMPLE_W-1:0] : dq_reg[SAMPLE_W-1:0];
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    latest_reg  <= smp_reg;
                    average_reg <= avg_reg;
                    net_reg     <= add_sum[NET_W-1:0];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/shwa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shwa_checker: port-level checks for the window average block
// Watches the handshakes and the sequencing seen at the top level's ports.
// ----------------------------------------------------------------------------
module shwa_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      sample_valid,
    input wire                      sample_ready,
    input wire                      result_valid,
    input wire                      result_ready,
    input wire shwa_pkg::sample_t   latest_sample,
    input wire shwa_pkg::sample_t   window_average,
    input wire shwa_pkg::net_t      net_value
);
    import shwa_pkg::*;

    // A result that is not taken stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(latest_sample) && $stable(window_average) && $stable(net_value))
        else $error("result payload changed while stalled");

    // The block works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second sample taken while the first is in work");

    // A new result appears only at the end of the work on a sample.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result offered without a sample in work");

endmodule

bind sample_history_window_average_top shwa_checker u_shwa_checker (.*);

`default_nettype wire

/* tb/sample_history_window_average_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_history_window_average_top_test: self-checking bench for the block
// Streams load-cell samples through the windowed average under changing
// window lengths, tare offsets and handshake pressure, and compares every
// result transaction with an in-bench model of the history and the divider.
// ----------------------------------------------------------------------------
module sample_history_window_average_top_test;

    import shwa_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CHUNK_ITEMS = 100;
    localparam int DRAIN_WAIT  = 100;

    // One expected result transaction.
    typedef struct {
        sample_t latest;
        sample_t average;
        net_t    net;
    } window_result_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_ready;
    raw_t      raw_sample = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    sample_t   latest_sample;
    sample_t   window_average;
    net_t      net_value;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = REG_AVERAGE_COUNT;
    cfg_data_t cfg_data = '0;

    // Samples waiting to be offered, and results the block still owes us.
    raw_t           pending_samples[$];
    window_result_t expected_results[$];

    // Bench copy of the block state and its two registers.
    sample_t sample_history[DEPTH];
    int      history_pos = 0;
    count_t  window_count = count_t'(1);
    sample_t window_offset = '0;

    // Handshake pressure, in percent, set per phase by the stimulus process.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    logic sample_taken = 1'b0;
    int   error_count = 0;

    sample_history_window_average_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .raw_sample     (raw_sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .latest_sample  (latest_sample),
        .window_average (window_average),
        .net_value      (net_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the write position, store the new sample and form the
    // truncated mean of the newest entries. The window length register is
    // clamped to 1..DEPTH, and entries never written still hold zero.
    function automatic window_result_t predict_window(input raw_t raw);
        window_result_t r;
        int             n;
        int             k;
        longint         acc;
        longint         avg;
        history_pos = (history_pos + 1) % DEPTH;
        sample_history[history_pos] = sample_t'(raw);
        n = int'(window_count);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        acc = 0;
        for (k = 0; k < n; k++)
            acc += longint'(sample_history[(history_pos + DEPTH - k) % DEPTH]);
        // Signed division in SystemVerilog truncates toward zero.
        avg = acc / longint'(n);
        r.latest  = sample_t'(raw);
        r.average = sample_t'(avg);
        r.net     = net_t'(avg - longint'(window_offset));
        return r;
    endfunction

    // Sample driver. A new transaction is offered only when the line is free
    // or the previous one was taken at the last rising edge, so valid and the
    // payload never change while a transaction waits.
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || sample_taken)
        begin
            if (pending_samples.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct)
            begin
                sample_valid <= 1'b1;
                raw_sample   <= pending_samples.pop_front();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Result receiver: stalls at random according to the current phase.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Monitor. Everything is sampled at the rising edge, where the inputs
    // have been stable for half a period. Accepted samples feed the model,
    // accepted register writes update its copy of the registers, and each
    // accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        window_result_t want;
        if (!rst_n)
            sample_taken <= 1'b0;
        else
        begin
            sample_taken <= sample_valid && sample_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_AVERAGE_COUNT)
                    window_count = cfg_data[CNT_W-1:0];
                else if (cfg_index == REG_ZERO_OFFSET)
                    window_offset = sample_t'(cfg_data);
            end
            if (sample_valid && sample_ready)
                expected_results.push_back(predict_window(raw_sample));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result transaction: latest %0d average %0d net %0d",
                             $time, latest_sample, window_average, net_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (latest_sample !== want.latest)
                    begin
                        error_count++;
                        $display("%0t: latest_sample mismatch: expected %0d, actual %0d",
                                 $time, want.latest, latest_sample);
                    end
                    if (window_average !== want.average)
                    begin
                        error_count++;
                        $display("%0t: window_average mismatch: expected %0d, actual %0d",
                                 $time, want.average, window_average);
                    end
                    if (net_value !== want.net)
                    begin
                        error_count++;
                        $display("%0t: net_value mismatch: expected %0d, actual %0d",
                                 $time, want.net, net_value);
                    end
                end
            end
        end
    end

    // One register write transaction on the configuration channel.
    task automatic write_register(input cfg_idx_t idx, input cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int count, input cfg_data_t offset);
        write_register(REG_AVERAGE_COUNT, cfg_data_t'(count));
        write_register(REG_ZERO_OFFSET, offset);
    endtask

    // Returns once every queued sample has been taken and answered, which is
    // the only time the registers may be rewritten.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_valid ||
               expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Random sample: mostly full-range words, with extra weight on values
    // near zero (to exercise truncation of negative sums) and near the
    // two extremes (to exercise the widest sums).
    function automatic raw_t random_raw();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
            1, 2: return raw_t'($urandom_range(0, 64) - 32);
            3: return raw_t'(24'h7FFFFF - $urandom_range(0, 255));
            4: return raw_t'(24'h800000 + $urandom_range(0, 255));
            default: return raw_t'($urandom());
        endcase
    endfunction

    // Window length for one chunk: in every run of six chunks the extremes and
    // the saturating values come first, and the sixth draws from the whole five-bit range.
    function automatic int pick_count(input int chunk);
        case (chunk % 6)
            0: return DEPTH;
            1: return 1;
            2: return 0;
            3: return 31;
            4: return DEPTH + 1;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic cfg_data_t pick_offset(input int chunk);
        case (chunk % 4)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            default: return cfg_data_t'($urandom());
        endcase
    endfunction

    initial
    begin
        int phase;
        int chunk;
        int i;

        for (i = 0; i < DEPTH; i++)
            sample_history[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, with no idling on either side. The first samples
        // run with the reset values of both registers.
        pending_samples.push_back(24'h000000);
        pending_samples.push_back(24'h7FFFFF);
        pending_samples.push_back(24'h800000);
        wait_drained();

        // A full window right after reset still reaches entries that were
        // never written; small negative sums check truncation toward zero.
        configure(DEPTH, 24'h800000);
        pending_samples.push_back(24'hFFFFFF);
        pending_samples.push_back(24'hFFFFFE);
        pending_samples.push_back(24'h000001);
        pending_samples.push_back(24'h800000);
        pending_samples.push_back(24'h800000);
        pending_samples.push_back(24'h7FFFFF);
        wait_drained();

        // A length of zero acts as one; with the most negative offset the
        // largest sample gives the largest net value.
        write_register(REG_AVERAGE_COUNT, cfg_data_t'(0));
        pending_samples.push_back(24'h7FFFFF);
        pending_samples.push_back(24'hFFFFFF);
        wait_drained();

        // The most negative sample against the largest offset.
        configure(1, 24'h7FFFFF);
        pending_samples.push_back(24'h800000);
        wait_drained();

        // A length above the history depth saturates to the full depth.
        write_register(REG_AVERAGE_COUNT, cfg_data_t'(31));
        pending_samples.push_back(24'h7FFFFF);
        pending_samples.push_back(24'h800001);
        pending_samples.push_back(24'hFFFFFD);
        pending_samples.push_back(24'h000003);
        wait_drained();

        configure(3, 24'h000001);
        pending_samples.push_back(24'hFFFFFF);
        pending_samples.push_back(24'hFFFFFF);
        pending_samples.push_back(24'h000001);
        wait_drained();

        // Random part: four pressure phases, each split into chunks that
        // run under a fresh window length and tare offset.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            for (chunk = 0; chunk < 3; chunk++)
            begin
                wait_drained();
                configure(pick_count(phase * 3 + chunk), pick_offset(phase + chunk));
                for (i = 0; i < CHUNK_ITEMS; i++)
                    pending_samples.push_back(random_raw());
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("PASS sample_history_window_average_top");
        else
            $display("FAIL sample_history_window_average_top");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial
    begin
        #20_000_000;
        $display("FAIL sample_history_window_average_top");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/shwa_pkg.sv
hw/rtl/sample_history_window_average_top.sv
hw/rtl/shwa_checker.sv
tb/sample_history_window_average_top_test.sv
